// ===== hdl/nmt_pkg.sv =====
// ----------------------------------------------------------------------------
// nmt_pkg
// Shared widths, fixed-point constants and the elaboration-time tanh sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package nmt_pkg;

  localparam int unsigned DataW     = 16;  // activation / weight width
  localparam int unsigned ProdW     = 2 * DataW;
  localparam int unsigned SpanShift = 29;  // 8.0 in the Q.26 sum
  localparam int unsigned InterpW   = DataW + SpanShift + 2;

  localparam logic [DataW-1:0] Q14One = 16'd16384;

  // Restoring divide, used only while building constant tables.
  function automatic logic [63:0] nmt_udiv(input logic [63:0] num,
                                           input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh(8*idx/entries) in unsigned Q1.14: odd series seed, then ten
  // rounds of t = 2t / (1 + t^2) on Q.30 values.
  function automatic logic [DataW-1:0] nmt_tanh_sample(input int unsigned idx,
                                                       input int unsigned entries);
    logic [63:0] x;
    logic [63:0] a;
    logic [63:0] cube;
    logic [63:0] t;
    logic [63:0] den;
    logic [63:0] r;
    x    = nmt_udiv(64'(idx) << 33, 64'(entries));
    a    = x >> 10;
    cube = (((a * a) >> 30) * a) >> 30;
    t    = a - cube / 64'd3;
    for (int k = 0; k < 10; k++) begin
      den = (64'd1 << 30) + ((t * t) >> 30);
      t   = nmt_udiv(t << 31, den);
    end
    r = (t + 64'h8000) >> 16;
    return r[DataW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/neuron_mac_tanh.sv =====
// ----------------------------------------------------------------------------
// neuron_mac_tanh
// One neuron: weighted-sum accumulator followed by a tanh activation.
// ----------------------------------------------------------------------------
// Each input beat brings one predecessor activation (Q1.14) and its weight
// (Q3.12). The exact Q4.26 product is added into a signed ACC_BITS-wide
// running sum that saturates at its bounds instead of wrapping. A beat with
// last_term_i set adds its own product first, then the sum is handed to the
// activation unit and the accumulator clears for the next neuron. The result
// is tanh of the sum in Q1.14: sums at or beyond +/-8.0 give +/-16384, and
// inside that span the magnitude is interpolated linearly between two
// samples of a TANH_TABLE_ENTRIES+1 entry ROM and rounded half up. The ROM is
// built at elaboration and split into even and odd banks so both neighbors
// come out of one registered read. Rate: beats without last_term_i are taken
// one per cycle. A last beat keeps in_ready_o low while it passes through
// the product, accumulate, range check, scale and ROM read, slope multiply
// and round registers into the output register; the hold stretches only if
// the previous result is still waiting in the output register at that point.
// A finished result waits in the output register without blocking the input.
// ----------------------------------------------------------------------------
`default_nettype none

module neuron_mac_tanh #(
  parameter int unsigned TANH_TABLE_ENTRIES = 256,
  parameter int unsigned ACC_BITS           = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [nmt_pkg::DataW-1:0]  activation_in_i,
  input  logic signed [nmt_pkg::DataW-1:0]  weight_i,
  input  logic                              last_term_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [nmt_pkg::DataW-1:0]  activation_out_o
);
  import nmt_pkg::*;

  logic                       in_fire;
  logic                       busy_q;
  logic                       sum_valid;
  logic signed [ACC_BITS-1:0] sum;
  logic                       res_valid;
  logic signed [DataW-1:0]    res;
  logic                       res_ready;
  logic                       res_fire;
  logic                       out_valid_q;
  logic signed [DataW-1:0]    out_data_q;

  // Input stays closed from a last beat until its result is in the
  // output register; that keeps a single sum in the activation unit.
  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;

  nmt_mac #(
    .ACC_BITS (ACC_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .act_i       (activation_in_i),
    .weight_i    (weight_i),
    .last_i      (last_term_i),
    .sum_valid_o (sum_valid),
    .sum_o       (sum)
  );

  nmt_tanh #(
    .ENTRIES  (TANH_TABLE_ENTRIES),
    .ACC_BITS (ACC_BITS)
  ) u_tanh (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (sum_valid),
    .sum_i       (sum),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready = !out_valid_q || out_ready_i;
  assign res_fire  = res_valid && res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire && last_term_i) begin
        busy_q <= 1'b1;
      end else if (res_fire) begin
        busy_q <= 1'b0;
      end
      if (res_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign activation_out_o = out_data_q;

  // ---- checks ----

  // a result only leaves the activation unit for a pending last beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire |-> busy_q)
    else $error("tanh result without a pending last beat");

  // never more than one sum in flight between accumulator and output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sum_valid && res_valid))
    else $error("two sums in flight in the activation path");

  // input reopens only once the result sits in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> out_valid_o)
    else $error("input reopened without a loaded result");

  // tanh output stays within plus or minus one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(activation_out_o) <= $signed(16'sd16384) &&
                     $signed(activation_out_o) >= $signed(-16'sd16384)))
    else $error("activation out of range");

endmodule

`default_nettype wire

// ===== hdl/nmt_mac.sv =====
// ----------------------------------------------------------------------------
// nmt_mac
// Product register and saturating accumulator; hands the sum off on last.
// ----------------------------------------------------------------------------
`default_nettype none

module nmt_mac #(
  parameter int unsigned ACC_BITS = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_fire_i,
  input  logic signed [nmt_pkg::DataW-1:0]  act_i,
  input  logic signed [nmt_pkg::DataW-1:0]  weight_i,
  input  logic                              last_i,
  output logic                              sum_valid_o,
  output logic signed [ACC_BITS-1:0]        sum_o
);
  import nmt_pkg::*;

  localparam logic signed [ACC_BITS-1:0] AccMax = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] AccMin = {1'b1, {(ACC_BITS-1){1'b0}}};

  logic signed [ProdW-1:0]    prod_q;
  logic                       last_q;
  logic                       vld_q;
  logic signed [ACC_BITS-1:0] acc_q, acc_d;
  logic signed [ACC_BITS-1:0] sum_q;
  logic                       sum_vld_q;
  logic signed [ACC_BITS:0]   sum_wide;
  logic                       ovf;
  logic signed [ACC_BITS-1:0] sat_sum;

  always_comb begin
    sum_wide = (ACC_BITS+1)'(acc_q) + (ACC_BITS+1)'(prod_q);
    ovf      = sum_wide[ACC_BITS] != sum_wide[ACC_BITS-1];
    if (ovf) begin
      sat_sum = sum_wide[ACC_BITS] ? AccMin : AccMax;
    end else begin
      sat_sum = sum_wide[ACC_BITS-1:0];
    end
    acc_d = acc_q;
    if (vld_q) begin
      acc_d = last_q ? '0 : sat_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      acc_q     <= '0;
      sum_vld_q <= 1'b0;
    end else begin
      vld_q     <= in_fire_i;
      acc_q     <= acc_d;
      sum_vld_q <= vld_q && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      prod_q <= act_i * weight_i;
      last_q <= last_i;
    end
    if (vld_q && last_q) begin
      sum_q <= sat_sum;
    end
  end

  assign sum_valid_o = sum_vld_q;
  assign sum_o       = sum_q;

endmodule

`default_nettype wire

// ===== hdl/nmt_rom.sv =====
// ----------------------------------------------------------------------------
// nmt_rom
// Tanh sample ROM split into even and odd banks, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module nmt_rom #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned EVEN_AW = 8,
  parameter int unsigned ODD_AW  = 7
) (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [EVEN_AW-1:0]        even_addr_i,
  input  logic [ODD_AW-1:0]         odd_addr_i,
  output logic [nmt_pkg::DataW-1:0] even_data_o,
  output logic [nmt_pkg::DataW-1:0] odd_data_o
);
  import nmt_pkg::*;

  localparam int unsigned EvenDepth = (ENTRIES + 2) / 2;
  localparam int unsigned OddDepth  = (ENTRIES + 1) / 2;

  typedef logic [DataW-1:0] even_tbl_t [EvenDepth];
  typedef logic [DataW-1:0] odd_tbl_t  [OddDepth];

  function automatic even_tbl_t build_even();
    even_tbl_t tbl;
    for (int k = 0; k < int'(EvenDepth); k++) begin
      tbl[k] = nmt_tanh_sample(2 * k, ENTRIES);
    end
    return tbl;
  endfunction

  function automatic odd_tbl_t build_odd();
    odd_tbl_t tbl;
    for (int k = 0; k < int'(OddDepth); k++) begin
      tbl[k] = nmt_tanh_sample(2 * k + 1, ENTRIES);
    end
    return tbl;
  endfunction

  localparam even_tbl_t EvenRom = build_even();
  localparam odd_tbl_t  OddRom  = build_odd();

  logic [DataW-1:0] even_q;
  logic [DataW-1:0] odd_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      even_q <= EvenRom[even_addr_i];
      odd_q  <= OddRom[odd_addr_i];
    end
  end

  assign even_data_o = even_q;
  assign odd_data_o  = odd_q;

endmodule

`default_nettype wire

// ===== hdl/nmt_tanh.sv =====
// ----------------------------------------------------------------------------
// nmt_tanh
// Tanh of the Q.26 sum: range check, index split, ROM pair read, lerp.
// ----------------------------------------------------------------------------
`default_nettype none

module nmt_tanh #(
  parameter int unsigned ENTRIES  = 256,
  parameter int unsigned ACC_BITS = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              sum_valid_i,
  input  logic signed [ACC_BITS-1:0]        sum_i,
  output logic                              res_valid_o,
  output logic signed [nmt_pkg::DataW-1:0]  res_o,
  input  logic                              res_ready_i
);
  import nmt_pkg::*;

  localparam int unsigned NW        = $clog2(ENTRIES + 1);
  localparam int unsigned PW        = SpanShift + NW;
  localparam int unsigned IdxW      = $clog2(ENTRIES);
  localparam int unsigned EvenDepth = (ENTRIES + 2) / 2;
  localparam int unsigned OddDepth  = (ENTRIES + 1) / 2;
  localparam int unsigned EvenAw    = $clog2(EvenDepth);
  localparam int unsigned OddAw     = $clog2(OddDepth);
  localparam logic signed [InterpW-1:0] Half = InterpW'(1) << (SpanShift - 1);

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1: sign, range, magnitude
  logic [ACC_BITS-1:0]   mag_full;
  logic                  neg1_q, sat1_q;
  logic [SpanShift-1:0]  mag1_q;

  // stage 2: scaled position, ROM request
  logic [PW-1:0]         pos;
  logic [IdxW-1:0]       idx;
  logic [IdxW:0]         idx_inc;
  logic [EvenAw-1:0]     even_addr;
  logic [OddAw-1:0]      odd_addr;
  logic [DataW-1:0]      even_data, odd_data;
  logic                  neg2_q, sat2_q, par2_q;
  logic [SpanShift-1:0]  frac2_q;

  // stage 3: slope times fraction
  logic [DataW-1:0]          lo, hi;
  logic signed [DataW:0]     diff;
  logic signed [InterpW-1:0] slope_prod;
  logic signed [InterpW-1:0] prod3_q;
  logic [DataW-1:0]          lo3_q;
  logic                      neg3_q, sat3_q;

  // stage 4: round and sign
  logic signed [InterpW-1:0] interp;
  logic [DataW-1:0]          mag_v, fin;
  logic [DataW-1:0]          res4_q;

  always_comb begin
    mag_full = sum_i[ACC_BITS-1] ? ACC_BITS'(-sum_i) : ACC_BITS'(sum_i);
  end

  always_comb begin
    pos       = PW'(mag1_q) * PW'(ENTRIES);
    idx       = pos[SpanShift +: IdxW];
    idx_inc   = {1'b0, idx} + 1'b1;
    even_addr = idx_inc[EvenAw:1];
    odd_addr  = idx[OddAw:1];
  end

  nmt_rom #(
    .ENTRIES (ENTRIES),
    .EVEN_AW (EvenAw),
    .ODD_AW  (OddAw)
  ) u_rom (
    .clk_i       (clk_i),
    .rd_en_i     (v1_q),
    .even_addr_i (even_addr),
    .odd_addr_i  (odd_addr),
    .even_data_o (even_data),
    .odd_data_o  (odd_data)
  );

  always_comb begin
    lo         = par2_q ? odd_data : even_data;
    hi         = par2_q ? even_data : odd_data;
    diff       = $signed({1'b0, hi}) - $signed({1'b0, lo});
    slope_prod = InterpW'(diff) * InterpW'($signed({1'b0, frac2_q}));
  end

  always_comb begin
    interp = $signed({2'b00, lo3_q, {SpanShift{1'b0}}}) + prod3_q + Half;
    mag_v  = interp[SpanShift +: DataW];
    fin    = sat3_q ? Q14One : mag_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= sum_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (v3_q) begin
        v4_q <= 1'b1;
      end else if (res_ready_i) begin
        v4_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_valid_i) begin
      neg1_q <= sum_i[ACC_BITS-1];
      sat1_q <= |mag_full[ACC_BITS-1:SpanShift];
      mag1_q <= mag_full[SpanShift-1:0];
    end
    if (v1_q) begin
      neg2_q  <= neg1_q;
      sat2_q  <= sat1_q;
      par2_q  <= idx[0];
      frac2_q <= pos[SpanShift-1:0];
    end
    if (v2_q) begin
      prod3_q <= slope_prod;
      lo3_q   <= lo;
      neg3_q  <= neg2_q;
      sat3_q  <= sat2_q;
    end
    if (v3_q) begin
      res4_q <= neg3_q ? DataW'(-fin) : fin;
    end
  end

  assign res_valid_o = v4_q;
  assign res_o       = res4_q;

endmodule

`default_nettype wire

// ===== tb/neuron_mac_tanh_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neuron_mac_tanh_tb
// Self-checking bench for the neuron weighted-sum and tanh activation unit.
// ----------------------------------------------------------------------------
// Beats of (activation, weight, last) go in through a valid/ready sender.
// A model inside the bench keeps its own saturating Q.26 sum and its own tanh
// sample table, and queues the expected Q1.14 output for each last beat. A
// checker pops that queue on every output beat and compares. Runs cover
// directed corner values, both accumulator clamps, a long receiver stall, and
// random neurons of mixed length and magnitude under three idling patterns.
// ----------------------------------------------------------------------------

module neuron_mac_tanh_tb;

  localparam int unsigned DW          = nmt_pkg::DataW;
  localparam int unsigned TanhEntries = 256;
  localparam int unsigned AccBits     = 40;

  // Accumulator clamp values and the +/-8.0 edge of the table, all Q.26.
  localparam longint SumMax  = (longint'(1) <<< (AccBits - 1)) - 1;
  localparam longint SumMin  = -SumMax - 1;
  localparam longint SpanSum = longint'(1) <<< nmt_pkg::SpanShift;

  // Directed, clamp and stall tests take about 1100 beats; this tops it up.
  localparam int unsigned RandomBeats = 450;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports. Everything starts at a known value.
  // --------------------------------------------------------------------------
  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_ready_o;
  logic signed [DW-1:0] activation_in_i  = '0;
  logic signed [DW-1:0] weight_i         = '0;
  logic                 last_term_i      = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i      = 1'b0;
  logic signed [DW-1:0] activation_out_o;

  always #5 clk_i = ~clk_i;

  neuron_mac_tanh #(
    .TANH_TABLE_ENTRIES(TanhEntries),
    .ACC_BITS          (AccBits)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .activation_in_i (activation_in_i),
    .weight_i        (weight_i),
    .last_term_i     (last_term_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .activation_out_o(activation_out_o)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  logic        [DW-1:0] tanh_samples [0:TanhEntries];  // unsigned Q1.14
  longint               neuron_sum = 0;                 // model of the Q.26 sum
  logic signed [DW-1:0] expected_activations [$];
  int                   errors = 0;

  // Idle odds in percent; the sender's is used only by the stimulus process.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Long receiver hold: the test flips hold_req, the receiver counts it down.
  logic        hold_req  = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_len  = 0;
  int unsigned hold_left = 0;

  // --------------------------------------------------------------------------
  // Model: tanh table, saturating sum, interpolated activation
  // --------------------------------------------------------------------------

  // tanh(8*i/N) in Q1.14: cubic series seed on Q.30, then ten rounds of
  // t <- 2t / (1 + t^2), then round off the low 16 bits.
  function automatic logic [DW-1:0] tanh_point(input int unsigned i);
    logic [63:0] x;
    logic [63:0] a;
    logic [63:0] cube;
    logic [63:0] t;
    logic [63:0] den;
    logic [63:0] r;
    x    = (64'(i) << 33) / 64'(TanhEntries);
    a    = x >> 10;
    cube = (((a * a) >> 30) * a) >> 30;
    t    = a - cube / 64'd3;
    for (int k = 0; k < 10; k++) begin
      den = (64'd1 << 30) + ((t * t) >> 30);
      t   = (t << 31) / den;
    end
    r = (t + 64'h8000) >> 16;
    return r[DW-1:0];
  endfunction

  // Clamp instead of wrap at the accumulator bounds.
  function automatic void add_product(input logic signed [DW-1:0] act,
                                      input logic signed [DW-1:0] wgt);
    longint prod;
    prod = longint'(act) * longint'(wgt);
    if (prod > 0 && neuron_sum > SumMax - prod)
      neuron_sum = SumMax;
    else if (prod < 0 && neuron_sum < SumMin - prod)
      neuron_sum = SumMin;
    else
      neuron_sum = neuron_sum + prod;
  endfunction

  // Odd-symmetric tanh: interpolate on |sum|, round half up, restore sign.
  function automatic logic signed [DW-1:0] tanh_of(input longint s);
    logic [63:0] mag;
    logic [63:0] pos;
    logic [63:0] frac;
    logic [63:0] idx;
    logic [63:0] v;
    if (s >= SpanSum || s <= -SpanSum) begin
      v = 64'(nmt_pkg::Q14One);
    end else begin
      mag  = (s < 0) ? 64'(-s) : 64'(s);
      pos  = mag * 64'(TanhEntries);
      idx  = pos >> nmt_pkg::SpanShift;
      frac = pos & ((64'd1 << nmt_pkg::SpanShift) - 64'd1);
      if (idx >= 64'(TanhEntries)) idx = 64'(TanhEntries) - 64'd1;
      v = (64'(tanh_samples[idx]) * ((64'd1 << nmt_pkg::SpanShift) - frac)
           + 64'(tanh_samples[idx + 1]) * frac
           + (64'd1 << (nmt_pkg::SpanShift - 1))) >> nmt_pkg::SpanShift;
    end
    if (s < 0) v = -v;
    return v[DW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random ready, or a counted hold when a test asks for one
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= hold_len;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every output beat against the oldest expected activation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_outputs
    logic signed [DW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_activations.size() == 0) begin
        $display("%0t: activation_out unexpected beat: expected none, got %0d",
                 $time, activation_out_o);
        errors++;
      end else begin
        want = expected_activations.pop_front();
        if (activation_out_o !== want) begin
          $display("%0t: activation_out mismatch: expected %0d, got %0d",
                   $time, want, activation_out_o);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // One input beat. Optional idle cycles first (valid low), then hold valid
  // until the handshake. The model is updated on acceptance.
  task automatic send_term(input logic signed [DW-1:0] act,
                           input logic signed [DW-1:0] wgt,
                           input logic                 last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    activation_in_i <= act;
    weight_i        <= wgt;
    last_term_i     <= last;
    do @(posedge clk_i); while (!in_ready_o);
    add_product(act, wgt);
    if (last) begin
      expected_activations.insert(expected_activations.size(), tanh_of(neuron_sum));
      neuron_sum = 0;
    end
  endtask

  // Sender goes quiet until every expected activation has come back.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_activations.size() != 0) @(posedge clk_i);
  endtask

  // Full range, a few hard corners, or scaled down to set the magnitude.
  function automatic logic signed [DW-1:0] rand_field(input int unsigned shift);
    logic signed [DW-1:0] v;
    v = DW'($urandom);
    case ($urandom_range(0, 19))
      0:       v = 16'sh8000;
      1:       v = 16'sh7fff;
      2:       v = '0;
      3:       v = -16'sd1;
      default: v = v >>> shift;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // One-beat neurons at the field extremes and around +/-8.0.
  task automatic test_single_term_neurons();
    send_term(16'sh7fff, 16'sh7fff, 1'b1);   // far above span
    send_term(16'sh8000, 16'sh7fff, 1'b1);   // far below span
    send_term(16'sh8000, 16'sh8000, 1'b1);   // largest product, +2^30
    send_term(16'sd0,    16'sd0,    1'b1);   // zero sum
    send_term(16'sd16384, 16'sd4096, 1'b1);  // 1.0 * 1.0
    send_term(-16'sd16384, 16'sd4096, 1'b1); // -1.0
    send_term(16'sd1,    16'sd1,    1'b1);   // smallest positive sum
    send_term(-16'sd1,   16'sd1,    1'b1);   // smallest negative sum
    send_term(16'sh8000, -16'sd16384, 1'b1); // exactly +8.0
    send_term(16'sh8000, 16'sd16384, 1'b1);  // exactly -8.0
    send_term(16'sd32767, 16'sd16384, 1'b1); // just under +8.0
    send_term(16'sd512,  16'sd4096, 1'b1);   // lands on a table sample
    send_term(16'sd513,  -16'sd4095, 1'b1);  // between two samples
    wait_results_drained();
  endtask

  // Multi-beat neurons: sum reaching the last table interval, cancellation,
  // and a last beat that pulls the sum back inside the span.
  task automatic test_table_edges();
    send_term(16'sd16384, 16'sd32767, 1'b0);  // 2^29 - 2^14
    send_term(16'sd1,     16'sd16383, 1'b1);  // +2^14 - 1: top of table
    send_term(-16'sd16384, 16'sd32767, 1'b0);
    send_term(-16'sd1,    16'sd16383, 1'b1);  // mirror, bottom of table
    send_term(16'sh7fff,  16'sh7fff, 1'b0);
    send_term(16'sh7fff,  16'sh8001, 1'b1);   // exact cancel to zero
    send_term(16'sh8000,  16'sh8000, 1'b0);   // 16.0
    send_term(16'sh8000,  16'sd28000, 1'b0);
    send_term(16'sd1234,  -16'sd777, 1'b1);   // back to about 2.3
    wait_results_drained();
  endtask

  // Drive the sum past a clamp and keep pushing, then nudge it back a little
  // on the last beat. A wrapping sum would come out with the opposite sign.
  task automatic test_sum_saturation(input logic towards_negative);
    logic signed [DW-1:0] out_w;
    logic signed [DW-1:0] tail_a;
    out_w  = towards_negative ? 16'sh7fff : 16'sh8000;
    tail_a = towards_negative ? 16'sh7fff : 16'sh8000;
    repeat (520) send_term(16'sh8000, out_w, 1'b0);
    send_term(tail_a, 16'sd24576, 1'b1);      // about 3*2^28 the other way
    wait_results_drained();
  endtask

  // Receiver holds off for a long stretch while neurons keep coming: the
  // output register fills and the next last beat stalls the input.
  task automatic test_output_backpressure();
    hold_len <= 400;
    hold_req <= ~hold_req;
    for (int n = 0; n < 12; n++) begin
      send_term(rand_field(4), rand_field(5), 1'b0);
      send_term(rand_field(6), rand_field(3), 1'b0);
      send_term(rand_field(5), rand_field(5), 1'b1);
    end
    wait_results_drained();
  endtask

  // Random neurons: mostly short, some long, magnitude chosen per neuron so
  // sums land both inside the table span and in the saturated region.
  task automatic test_random_neurons(input int unsigned beats,
                                     input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int unsigned left;
    int unsigned len;
    int unsigned shift_a;
    int unsigned shift_w;
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    left = beats;
    while (left > 0) begin
      case ($urandom_range(0, 9))
        0, 1:    len = 1;
        8, 9:    len = $urandom_range(9, 40);
        default: len = $urandom_range(2, 8);
      endcase
      if (len > left) len = left;
      shift_a = $urandom_range(0, 12);
      shift_w = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) begin
        shift_a = 0;
        shift_w = 0;
      end
      for (int k = 1; k <= len; k++)
        send_term(rand_field(shift_a), rand_field(shift_w), k == len);
      left -= len;
    end
    wait_results_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i <= TanhEntries; i++) tanh_samples[i] = tanh_point(i);

    send_idle_pct = 32;
    recv_idle_pct <= 51;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_term_neurons();
    test_table_edges();
    test_sum_saturation(1'b0);
    test_sum_saturation(1'b1);
    test_output_backpressure();

    // Three idling patterns: sender/receiver, swapped, then none at all.
    test_random_neurons(RandomBeats / 3, 32, 51);
    test_random_neurons(RandomBeats / 3, 51, 32);
    test_random_neurons(RandomBeats - 2 * (RandomBeats / 3), 0, 0);

    // Wait out the pipeline and catch any stray beats.
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("neuron_mac_tanh verification clean");
    end else begin
      $display("neuron_mac_tanh verification failed");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("neuron_mac_tanh verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/nmt_pkg.sv
hdl/nmt_mac.sv
hdl/nmt_rom.sv
hdl/nmt_tanh.sv
hdl/neuron_mac_tanh.sv
tb/neuron_mac_tanh_tb.sv
